### rtl/lbgpd_pkg.sv
// Shared constants and types for the bar graph peak decay renderer.
package lbgpd_pkg;

    localparam int COLUMNS   = 8;
    localparam int ROWS      = 32;
    localparam int MAX_EMIT  = 32;
    localparam int EMIT_ROWS = (ROWS > MAX_EMIT) ? MAX_EMIT : ROWS;
    localparam int COL_IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam int COL_W    = 3;
    localparam int HEIGHT_W = 8;
    localparam int ROW_W    = 5;
    localparam int COLOUR_W = 24;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 32;
    localparam int CFG_W    = 24;

    localparam logic [ROW_W-1:0]    LAST_ROW     = ROW_W'(EMIT_ROWS - 1);
    localparam logic [COLOUR_W-1:0] DIM_COLOUR   = 24'h000001;
    localparam logic [HEIGHT_W-1:0] DECAY_RESET  = 8'd1;
    localparam logic [COLOUR_W-1:0] COLOUR_RESET = 24'hFFFFFF;

    typedef enum logic [0:0] {
        REG_DECAY  = 1'b0,
        REG_COLOUR = 1'b1
    } cfg_reg_t;

    // One column to draw, as handed from the front part to the back part.
    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [HEIGHT_W-1:0] height;
    } bar_job_t;

endpackage

### rtl/lbgpd_front.sv
// Input side: takes a beat, updates the stored column height and queues the column.
module lbgpd_front
    import lbgpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // column_index[2:0], new_height[10:3], zero pad
    input  logic [HEIGHT_W-1:0] decay_amount,
    input  logic                q_full,
    output logic                q_push,
    output bar_job_t            q_job
);

    logic [HEIGHT_W-1:0]  heights_reg [COLUMNS];
    logic [COL_W-1:0]     col;
    logic [HEIGHT_W-1:0]  fresh;
    logic [HEIGHT_W-1:0]  stored;
    logic [HEIGHT_W-1:0]  height_next;
    logic [COL_IDX_W-1:0] idx;
    logic                 in_range;
    logic                 accept;

    assign col      = s_tdata[COL_W-1:0];
    assign fresh    = s_tdata[COL_W +: HEIGHT_W];
    assign in_range = 32'(col) < COLUMNS;
    assign idx      = col[COL_IDX_W-1:0];
    assign stored   = heights_reg[idx];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept && in_range;

    always_comb
    begin
        priority if (fresh >= stored)
        begin
            height_next = fresh;
        end
        else if (stored > decay_amount)
        begin
            height_next = stored - decay_amount;
        end
        else
        begin
            height_next = '0;
        end
    end

    assign q_job.column = col;
    assign q_job.height = height_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COLUMNS; i++)
            begin
                heights_reg[i] <= '0;
            end
        end
        else if (q_push)
        begin
            heights_reg[idx] <= height_next;
        end
    end

endmodule

### rtl/lbgpd_queue.sv
// Two-entry queue of column jobs between the front and back parts.
module lbgpd_queue
    import lbgpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bar_job_t job_in,
    output logic     full,
    input  logic     pop,
    output logic     job_valid,
    output bar_job_t job_out
);

    localparam logic [1:0] DEPTH = 2'd2;

    bar_job_t   entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == DEPTH);
    assign job_valid = (count_reg != 2'd0);
    assign job_out   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/lbgpd_back.sv
// Output side: walks the rows of one column and drives the pixel beats.
module lbgpd_back
    import lbgpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  bar_job_t            job_in,
    output logic                pop,
    input  logic [COLOUR_W-1:0] bar_colour,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    output logic                m_tlast
);

    logic                busy_reg;
    bar_job_t            job_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;
    logic                out_last_reg;
    logic                load_out;
    logic                row_last;
    logic [COLOUR_W-1:0] colour_next;

    assign row_last = (row_reg == LAST_ROW);
    assign load_out = busy_reg && (!out_valid_reg || m_tready);
    // Take the next job when idle or while the final row of this one goes out.
    assign pop      = job_valid && (!busy_reg || (load_out && row_last));

    assign colour_next = ({{(HEIGHT_W-ROW_W){1'b0}}, row_reg} > job_reg.height) ?
                         DIM_COLOUR : bar_colour;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job_in;
        end
        if (load_out)
        begin
            out_data_reg <= {colour_next, row_reg, job_reg.column};
            out_last_reg <= row_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                row_reg  <= '0;
            end
            else if (load_out)
            begin
                if (row_last)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/led_bar_graph_peak_decay.sv
// Top level of the bar graph renderer with peak hold and decay.
//
//  channel | direction | payload
//  s_*     | in        | tdata: column_index[2:0], new_height[10:3]
//  m_*     | out       | tdata: out_column[2:0], out_row[7:3], pixel_colour[31:8]; tlast
//  cfg_*   | in        | index 0 decay_amount, index 1 bar_colour
//
// The back part sends one pixel beat per cycle while m_tready is high, one per row.
// A column goes via a queue entry and the job register into the output register.
// Reset clears all heights, sets decay_amount to 1 and bar_colour to 0xFFFFFF.
// With m_tready low the output beat holds; the front keeps taking beats until the
// two-entry queue is full, so up to three columns can wait behind the one on the output.
module led_bar_graph_peak_decay
    import lbgpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // column_index[2:0], new_height[10:3], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // out_column[2:0], out_row[7:3], pixel_colour[31:8]
    output logic             m_tlast,   // last_pixel
    input  logic             cfg_wr_en,
    input  cfg_reg_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [HEIGHT_W-1:0] decay_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    bar_job_t            q_job_in;
    bar_job_t            q_job_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg  <= DECAY_RESET;
            colour_reg <= COLOUR_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DECAY:  decay_reg  <= cfg_data[HEIGHT_W-1:0];
                REG_COLOUR: colour_reg <= cfg_data[COLOUR_W-1:0];
                default:    ;
            endcase
        end
    end

    lbgpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .decay_amount (decay_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job_in)
    );

    lbgpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .job_in    (q_job_in),
        .full      (q_full),
        .pop       (q_pop),
        .job_valid (q_valid),
        .job_out   (q_job_out)
    );

    lbgpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_valid),
        .job_in     (q_job_out),
        .pop        (q_pop),
        .bar_colour (colour_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

### rtl/lbgpd_checker.sv
// Port-level checks on the pixel stream, bound to the top level.
module lbgpd_checker
    import lbgpd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);

    logic [ROW_W-1:0]    exp_row_reg;
    logic [COL_W-1:0]    col_seen_reg;
    logic                dim_seen_reg;
    logic                beat;
    logic [COL_W-1:0]    out_col;
    logic [ROW_W-1:0]    out_row;
    logic [COLOUR_W-1:0] out_colour;

    assign beat       = m_tvalid && m_tready;
    assign out_col    = m_tdata[COL_W-1:0];
    assign out_row    = m_tdata[COL_W +: ROW_W];
    assign out_colour = m_tdata[COL_W+ROW_W +: COLOUR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_row_reg  <= '0;
            col_seen_reg <= '0;
            dim_seen_reg <= 1'b0;
        end
        else if (beat)
        begin
            if (m_tlast)
            begin
                exp_row_reg  <= '0;
                dim_seen_reg <= 1'b0;
            end
            else
            begin
                exp_row_reg  <= exp_row_reg + 1'b1;
                dim_seen_reg <= dim_seen_reg || (out_colour == DIM_COLOUR);
            end
            col_seen_reg <= out_col;
        end
    end

    // Rows of a column come out in order from the bottom.
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_row == exp_row_reg)
        else $error("pixel row out of sequence");

    // The last flag falls on the top emitted row and nowhere else.
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (out_row == LAST_ROW)))
        else $error("last pixel flag on wrong row");

    // All pixels of one column carry the same column.
    a_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && exp_row_reg != '0) |-> out_col == col_seen_reg)
        else $error("column changed within a bar");

    // Once a dim pixel appears, the rest of the bar is dim.
    a_dim_above: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && dim_seen_reg) |-> out_colour == DIM_COLOUR)
        else $error("lit pixel above a dim pixel");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output beat changed");

endmodule

bind led_bar_graph_peak_decay lbgpd_checker u_lbgpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### test/tb_top.sv
// Self-checking testbench for the bar graph renderer, with peak hold, decay and stream stalls.
`timescale 1ns / 1ps

module tb_top;
    import lbgpd_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int ITEMS_PER_RUN = 80;
    localparam int N_DIRECTED    = 24;

    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } pixel_t;

    typedef enum logic [0:0] {
        STEP_ITEM  = 1'b0,
        STEP_WRITE = 1'b1
    } step_kind_t;

    // A quoted height of -1 means the expected column comes from the shadow model.
    typedef struct packed {
        step_kind_t          kind;
        cfg_reg_t            target;
        logic [CFG_W-1:0]    value;
        logic [COL_W-1:0]    column;
        logic [HEIGHT_W-1:0] height;
        int                  quoted;
    } directed_step_t;

    directed_step_t directed_steps [N_DIRECTED] = '{
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd0, 8'd0,   0},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd0, 8'd255, 255},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd0, 8'd10,  254},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd7, 8'd255, 255},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd7, 8'd255, 255},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd3, 8'd31,  31},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd3, 8'd30,  30},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd5, 8'd1,   1},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd5, 8'd0,   0},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd5, 8'd0,   0},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd1, 8'd170, 170},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd2, 8'd85,  85},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd4, 8'd127, 127},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd6, 8'd128, 128},
        // With zero decay a lower height leaves the bar where it was.
        '{STEP_WRITE, REG_DECAY,  24'h0, 3'd0, 8'd0,   -1},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd6, 8'd5,   128},
        // Full decay drops any bar to zero, including one equal to the step.
        '{STEP_WRITE, REG_DECAY,  24'hABCDFF, 3'd0, 8'd0, -1},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd1, 8'd0,   0},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd7, 8'd254, 0},
        '{STEP_WRITE, REG_COLOUR, 24'h000000, 3'd0, 8'd0, -1},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd2, 8'd40,  -1},
        '{STEP_WRITE, REG_COLOUR, 24'hA5C35A, 3'd0, 8'd0, -1},
        '{STEP_ITEM,  REG_DECAY,  24'h0, 3'd3, 8'd16,  -1},
        '{STEP_WRITE, REG_DECAY,  24'h000003, 3'd0, 8'd0, -1}
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             cfg_wr_en = 1'b0;
    cfg_reg_t         cfg_index = REG_DECAY;
    logic [CFG_W-1:0] cfg_data = '0;

    // Shadow copy of the block's state and registers.
    logic [HEIGHT_W-1:0] bar_height_shadow [COLUMNS];
    logic [HEIGHT_W-1:0] decay_shadow = DECAY_RESET;
    logic [COLOUR_W-1:0] colour_shadow = COLOUR_RESET;

    pixel_t pending_pixels [$];
    int     quoted_heights [$];

    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles = 0;
    logic [7:0]  hold_seq = '0;
    logic [7:0]  hold_seen = '0;
    int          hold_left = 0;

    led_bar_graph_peak_decay i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int c = 0; c < COLUMNS; c++)
        begin
            bar_height_shadow[c] = '0;
        end
    end

    function automatic logic [HEIGHT_W-1:0] peak_decay_height(
        logic [HEIGHT_W-1:0] stored,
        logic [HEIGHT_W-1:0] fresh,
        logic [HEIGHT_W-1:0] step
    );
        if (fresh >= stored)
        begin
            return fresh;
        end
        if (stored > step)
        begin
            return stored - step;
        end
        return '0;
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Register shadow, column prediction and output checking all sit on one edge.
    always @(posedge clk)
    begin
        pixel_t              want;
        pixel_t              got;
        logic [COL_W-1:0]    col;
        logic [HEIGHT_W-1:0] next_h;
        int                  quoted;
        int                  lit;

        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_DECAY:  decay_shadow = cfg_data[HEIGHT_W-1:0];
                    REG_COLOUR: colour_shadow = cfg_data[COLOUR_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                col    = s_tdata[COL_W-1:0];
                next_h = peak_decay_height(bar_height_shadow[col],
                                           s_tdata[COL_W +: HEIGHT_W], decay_shadow);
                bar_height_shadow[col] = next_h;
                quoted = (quoted_heights.size() != 0) ? quoted_heights.pop_front() : -1;
                lit    = (quoted >= 0) ? quoted : int'(next_h);
                for (int r = 0; r < EMIT_ROWS; r++)
                begin
                    want.column = col;
                    want.row    = ROW_W'(r);
                    want.colour = (r > lit) ? DIM_COLOUR : colour_shadow;
                    want.last   = (r == EMIT_ROWS - 1);
                    pending_pixels.push_back(want);
                end
            end

            if (m_tvalid && m_tready)
            begin
                got.column = m_tdata[COL_W-1:0];
                got.row    = m_tdata[COL_W +: ROW_W];
                got.colour = m_tdata[COL_W+ROW_W +: COLOUR_W];
                got.last   = m_tlast;
                if (pending_pixels.size() == 0)
                begin
                    report_mismatch("beat with nothing pending", 0, m_tdata);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.column !== want.column)
                        report_mismatch("out_column", want.column, got.column);
                    if (got.row !== want.row)
                        report_mismatch("out_row", want.row, got.row);
                    if (got.colour !== want.colour)
                        report_mismatch("pixel_colour", want.colour, got.colour);
                    if (got.last !== want.last)
                        report_mismatch("last_pixel", want.last, got.last);
                end
            end
        end
    end

    // Output side: random back-pressure, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_column(logic [COL_W-1:0] col, logic [HEIGHT_W-1:0] h, int quoted);
        quoted_heights.push_back(quoted);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({h, col});
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // The extra edge lets the prediction for the last accepted beat land first.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(cfg_reg_t target, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= target;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_column();
        logic [COL_W-1:0]    col;
        logic [HEIGHT_W-1:0] h;
        int                  pick;

        col  = COL_W'($urandom_range(COLUMNS - 1));
        pick = $urandom_range(9);
        if (pick < 5)
            h = HEIGHT_W'($urandom_range(40));
        else if (pick < 7)
            h = HEIGHT_W'($urandom_range(255));
        else if (bar_height_shadow[col] != 0)
            h = HEIGHT_W'($urandom_range(bar_height_shadow[col] - 1));
        else
            h = '0;
        send_column(col, h, -1);
    endtask

    initial
    begin
        logic [HEIGHT_W-1:0] decay_plan [6];
        logic [COLOUR_W-1:0] colour_pick;

        decay_plan = '{8'd2, 8'd255, 8'd0, 8'd7, 8'd1, 8'd128};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_WRITE)
            begin
                wait_for_drain();
                write_register(directed_steps[i].target, directed_steps[i].value);
            end
            else
            begin
                send_column(directed_steps[i].column, directed_steps[i].height,
                            directed_steps[i].quoted);
            end
        end

        // Three idling patterns, each split into two register settings.
        for (int epoch = 0; epoch < 6; epoch++)
        begin
            case (epoch / 2)
                0:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 68;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 15;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            case (epoch)
                1:       colour_pick = 24'hFFFFFF;
                2:       colour_pick = 24'h000000;
                5:       colour_pick = DIM_COLOUR;
                default: colour_pick = COLOUR_W'($urandom);
            endcase

            wait_for_drain();
            write_register(REG_DECAY, {CFG_W'($urandom_range(16'hFFFF)) << HEIGHT_W}
                                      | CFG_W'(decay_plan[epoch]));
            write_register(REG_COLOUR, colour_pick);

            for (int n = 0; n < ITEMS_PER_RUN; n++)
            begin
                // Stall the output long enough that the input side backs up.
                if (epoch == 0 && n == 10)
                begin
                    hold_seq <= hold_seq + 1'b1;
                end
                send_random_column();
            end
        end

        wait_for_drain();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/lbgpd_pkg.sv
rtl/lbgpd_front.sv
rtl/lbgpd_queue.sv
rtl/lbgpd_back.sv
rtl/led_bar_graph_peak_decay.sv
rtl/lbgpd_checker.sv
test/tb_top.sv
